>>> hdl/fpmm_pkg.sv
// shared types, constants and helpers of the fixed-point matrix multiplier
`default_nettype none
package fpmm_pkg;

    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DIM_LIMIT     = 8;
    localparam int QUEUE_DEPTH   = 4;

    localparam int ELEM_W  = 32;
    localparam int CFG_W   = 4;
    localparam int CIDX_W  = 2;
    localparam int POS_W   = 3;
    localparam int SLOT_W  = $clog2(DIM_LIMIT * DIM_LIMIT);

    localparam logic [CIDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CIDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CIDX_W-1:0] REG_COLS_B    = 2'd2;

    localparam logic MAT_A = 1'b0;
    localparam logic MAT_B = 1'b1;

    // one classified item on its way from front to back
    typedef struct packed {
        logic                    wr;
        logic                    is_b;
        logic [SLOT_W-1:0]       addr;
        logic [ELEM_W-1:0]       value;
        logic                    run;
        logic [CFG_W-1:0]        rows;
        logic [CFG_W-1:0]        inner;
        logic [CFG_W-1:0]        cols;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DOT,
        BK_WAIT
    } back_state_t;

    // clamp a dimension register to 1 .. max_dim
    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] max_dim);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > max_dim) begin
            r = max_dim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/fixed_point_matrix_multiply.sv
// fixed-point matrix multiplier top level: front end, item queue, back end
// loads: one item per cycle while the four-entry queue has room
// each result accumulates inner_dim products through the single multiply-accumulate unit
// a run starts when the completing item leaves the queue
// a stalled result blocks the back end; the front keeps taking items until the queue fills
// reset: load counts clear, dimensions return to 8, matrix stores hold unknown data
`default_nettype none
module fixed_point_matrix_multiply
    import fpmm_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              push,
    output logic                   full,
    input  wire logic              req_type,
    input  wire logic [ELEM_W-1:0] element_value,
    output logic                   empty,
    input  wire logic              pop,
    output logic [ELEM_W-1:0]      product_value,
    output logic [POS_W-1:0]       out_row,
    output logic [POS_W-1:0]       out_col,
    output logic                   last_of_run
);

    job_t f_job, b_job;
    logic f_push, q_full, q_empty, q_pop;

    fpmm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .req_type      (req_type),
        .element_value (element_value),
        .q_push        (f_push),
        .q_job         (f_job),
        .q_full        (q_full)
    );

    fpmm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (f_push),
        .wr_job (f_job),
        .full   (q_full),
        .rd     (q_pop),
        .rd_job (b_job),
        .empty  (q_empty)
    );

    fpmm_back #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_job         (b_job),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .product_value (product_value),
        .out_row       (out_row),
        .out_col       (out_col),
        .last_of_run   (last_of_run)
    );

endmodule
`default_nettype wire

>>> hdl/fpmm_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module fpmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

>>> hdl/fpmm_front.sv
// front end: configuration registers, load counts and item classification
`default_nettype none
module fpmm_front
    import fpmm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              push,
    output logic                   full,
    input  wire logic              req_type,
    input  wire logic [ELEM_W-1:0] element_value,
    output logic                   q_push,
    output job_t                   q_job,
    input  wire logic              q_full
);

    localparam int CNT_W = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam logic [CFG_W-1:0] MAX_D = CFG_W'(MAX_DIM);

    logic [CFG_W-1:0] rows_reg, inner_reg, cols_reg;
    logic [CNT_W-1:0] a_cnt_reg, a_cnt_next, b_cnt_reg, b_cnt_next;
    logic [CFG_W-1:0] r, n, m;
    logic [7:0]       a_size, b_size;
    logic             accept, a_room, b_room, store, done;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign accept    = push && !q_full;

    assign r      = eff_dim(rows_reg, MAX_D);
    assign n      = eff_dim(inner_reg, MAX_D);
    assign m      = eff_dim(cols_reg, MAX_D);
    assign a_size = 8'(r) * 8'(n);
    assign b_size = 8'(n) * 8'(m);
    assign a_room = 8'(a_cnt_reg) < a_size;
    assign b_room = 8'(b_cnt_reg) < b_size;

    always_comb
    begin
        a_cnt_next = a_cnt_reg;
        b_cnt_next = b_cnt_reg;
        store      = 1'b0;
        if (req_type == MAT_A)
        begin
            if (a_room)
            begin
                a_cnt_next = a_cnt_reg + CNT_W'(1);
                store      = 1'b1;
            end
        end
        else
        begin
            if (b_room)
            begin
                b_cnt_next = b_cnt_reg + CNT_W'(1);
                store      = 1'b1;
            end
        end
        done = (8'(a_cnt_next) >= a_size) && (8'(b_cnt_next) >= b_size);
    end

    always_comb
    begin
        q_job.wr    = store;
        q_job.is_b  = req_type;
        q_job.addr  = (req_type == MAT_A) ? SLOT_W'(a_cnt_reg) : SLOT_W'(b_cnt_reg);
        q_job.value = element_value;
        q_job.run   = done;
        q_job.rows  = r;
        q_job.inner = n;
        q_job.cols  = m;
        q_push      = accept && (store || done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= CFG_W'(8);
            inner_reg <= CFG_W'(8);
            cols_reg  <= CFG_W'(8);
            a_cnt_reg <= '0;
            b_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_ROWS_A:    rows_reg  <= cfg_data;
                    REG_INNER_DIM: inner_reg <= cfg_data;
                    REG_COLS_B:    cols_reg  <= cfg_data;
                    default:       ;
                endcase
            end
            if (accept)
            begin
                a_cnt_reg <= done ? '0 : a_cnt_next;
                b_cnt_reg <= done ? '0 : b_cnt_next;
            end
        end
    end

endmodule
`default_nettype wire

>>> hdl/fpmm_queue.sv
// short queue of classified items between front and back
`default_nettype none
module fpmm_queue
    import fpmm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr,
    input  wire job_t wr_job,
    output logic      full,
    input  wire logic rd,
    output job_t      rd_job,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slots [DEPTH];
    logic [PTR_W-1:0] wp_reg, rp_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_wr, do_rd;

    assign full   = (cnt_reg == CNT_W'(DEPTH));
    assign empty  = (cnt_reg == '0);
    assign do_wr  = wr && !full;
    assign do_rd  = rd && !empty;
    assign rd_job = slots[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots[wp_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rp_reg <= (rp_reg == PTR_W'(DEPTH - 1)) ? '0 : rp_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

>>> hdl/fpmm_back.sv
// back end: matrix stores, one multiply-accumulate unit and result register
`default_nettype none
module fpmm_back
    import fpmm_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire job_t              q_job,
    input  wire logic              q_empty,
    output logic                   q_pop,
    output logic                   empty,
    input  wire logic              pop,
    output logic [ELEM_W-1:0]      product_value,
    output logic [POS_W-1:0]       out_row,
    output logic [POS_W-1:0]       out_col,
    output logic                   last_of_run
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int ACC_W = PROD_W + IDX_W + 1;

    back_state_t state_reg, state_next;

    logic [CFG_W-1:0] r_reg, n_reg, m_reg;
    logic [IDX_W-1:0] i_reg, j_reg, k_reg;
    logic [AW-1:0]    a_base_reg, a_run_reg, b_run_reg;

    logic [ELEM_W-1:0]        a_rd, b_rd;
    logic                     p1_v_reg, p1_first_reg, p1_last_reg;
    logic                     p2_v_reg, p2_first_reg, p2_last_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_sh;
    logic                     fin_reg;
    logic [ELEM_W-1:0]        sat_val;
    logic                     out_v_reg;

    logic start, issue, emit, dot_first, dot_last, row_end, mat_end, out_space;
    logic a_wr, b_wr;

    assign dot_first = (k_reg == '0);
    assign dot_last  = (CFG_W'(k_reg) + CFG_W'(1) == n_reg);
    assign row_end   = (CFG_W'(j_reg) + CFG_W'(1) == m_reg);
    assign mat_end   = row_end && (CFG_W'(i_reg) + CFG_W'(1) == r_reg);
    assign out_space = !out_v_reg || pop;
    assign empty     = !out_v_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty && q_job.run)
                begin
                    state_next = BK_DOT;
                end
            end
            BK_DOT:
            begin
                if (dot_last)
                begin
                    state_next = BK_WAIT;
                end
            end
            BK_WAIT:
            begin
                if (fin_reg && out_space)
                begin
                    state_next = mat_end ? BK_IDLE : BK_DOT;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop = 1'b0;
        start = 1'b0;
        issue = 1'b0;
        emit  = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                q_pop = !q_empty;
                start = !q_empty && q_job.run;
            end
            BK_DOT:  issue = 1'b1;
            BK_WAIT: emit  = fin_reg && out_space;
            default: ;
        endcase
    end

    assign a_wr = q_pop && q_job.wr && (q_job.is_b == MAT_A);
    assign b_wr = q_pop && q_job.wr && (q_job.is_b == MAT_B);

    fpmm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_a_ram (
        .clk     (clk),
        .wr_en   (a_wr),
        .wr_addr (AW'(q_job.addr)),
        .wr_data (q_job.value),
        .rd_addr (a_run_reg),
        .rd_data (a_rd)
    );

    fpmm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_b_ram (
        .clk     (clk),
        .wr_en   (b_wr),
        .wr_addr (AW'(q_job.addr)),
        .wr_data (q_job.value),
        .rd_addr (b_run_reg),
        .rd_data (b_rd)
    );

    // scale down with floor and saturate
    always_comb
    begin
        acc_sh = acc_reg >>> FRAC_BITS;
        if ((&acc_sh[ACC_W-1:ELEM_W-1]) || !(|acc_sh[ACC_W-1:ELEM_W-1]))
        begin
            sat_val = acc_sh[ELEM_W-1:0];
        end
        else if (acc_sh[ACC_W-1])
        begin
            sat_val = {1'b1, {(ELEM_W-1){1'b0}}};
        end
        else
        begin
            sat_val = {1'b0, {(ELEM_W-1){1'b1}}};
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= q_job.rows;
            n_reg <= q_job.inner;
            m_reg <= q_job.cols;
        end
        prod_reg <= $signed(a_rd) * $signed(b_rd);
        if (p2_v_reg)
        begin
            acc_reg <= (p2_first_reg ? '0 : acc_reg) + ACC_W'(prod_reg);
        end
        if (emit)
        begin
            product_value <= sat_val;
            out_row       <= POS_W'(i_reg);
            out_col       <= POS_W'(j_reg);
            last_of_run   <= mat_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            a_base_reg   <= '0;
            a_run_reg    <= '0;
            b_run_reg    <= '0;
            p1_v_reg     <= 1'b0;
            p1_first_reg <= 1'b0;
            p1_last_reg  <= 1'b0;
            p2_v_reg     <= 1'b0;
            p2_first_reg <= 1'b0;
            p2_last_reg  <= 1'b0;
            fin_reg      <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            p1_v_reg     <= issue;
            p1_first_reg <= dot_first;
            p1_last_reg  <= dot_last;
            p2_v_reg     <= p1_v_reg;
            p2_first_reg <= p1_first_reg;
            p2_last_reg  <= p1_last_reg;

            if (start)
            begin
                i_reg      <= '0;
                j_reg      <= '0;
                k_reg      <= '0;
                a_base_reg <= '0;
                a_run_reg  <= '0;
                b_run_reg  <= '0;
            end
            else if (issue)
            begin
                k_reg     <= dot_last ? '0 : k_reg + IDX_W'(1);
                a_run_reg <= a_run_reg + AW'(1);
                b_run_reg <= b_run_reg + AW'(m_reg);
            end
            else if (emit)
            begin
                if (row_end)
                begin
                    j_reg      <= '0;
                    i_reg      <= i_reg + IDX_W'(1);
                    a_base_reg <= a_base_reg + AW'(n_reg);
                    a_run_reg  <= a_base_reg + AW'(n_reg);
                    b_run_reg  <= '0;
                end
                else
                begin
                    j_reg     <= j_reg + IDX_W'(1);
                    a_run_reg <= a_base_reg;
                    b_run_reg <= AW'(j_reg) + AW'(1);
                end
            end

            if (emit)
            begin
                fin_reg <= 1'b0;
            end
            else if (p2_v_reg && p2_last_reg)
            begin
                fin_reg <= 1'b1;
            end

            if (emit)
            begin
                out_v_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire
